// File: hw/rtl/egcd_pkg.sv
// ---------------------------------------------------------------------------
// egcd_pkg: shared types and constants for the extended gcd unit
// Datapath width, field width, sequencer states and divider control structs.
// ---------------------------------------------------------------------------
package egcd_pkg;

    localparam int WIDTH   = 32;                    // internal datapath width
    localparam int FIELD_W = 32;                    // request/response field width
    localparam int CNT_W   = $clog2(WIDTH + 1);     // divider bit counter

    typedef logic [WIDTH-1:0]   t_word;
    typedef logic [FIELD_W-1:0] t_field;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV_START,
        ST_DIV_RUN,
        ST_FINISH
    } t_state;

    // request to the serial divide/multiply unit
    typedef struct packed {
        logic  start;
        t_word dividend;   // magnitude
        t_word divisor;    // magnitude, nonzero
        t_word mul_s;      // coefficient multiplied by the quotient
        t_word mul_t;
    } t_div_req;

    // status and results of the serial divide/multiply unit
    typedef struct packed {
        logic  busy;
        t_word remainder;  // magnitude
        t_word prod_s;     // quotient magnitude * mul_s, wrapped
        t_word prod_t;
    } t_div_res;

    // field -> datapath: sign extend, then keep WIDTH bits
    function automatic t_word from_field(input t_field f);
        logic [63:0] x;
        x = 64'($signed(f));
        return x[WIDTH-1:0];
    endfunction

    // datapath -> field: sign extend from WIDTH bits, then keep FIELD_W bits
    function automatic t_field to_field(input t_word v);
        logic [63:0] x;
        x = 64'($signed(v));
        return x[FIELD_W-1:0];
    endfunction

    function automatic t_word magnitude(input t_word v);
        return v[WIDTH-1] ? (~v + WIDTH'(1)) : v;
    endfunction

endpackage

// File: hw/rtl/egcd_if.sv
// ---------------------------------------------------------------------------
// egcd_if: request and response channels of the extended gcd unit
// Valid/ready handshake; a request moves when valid and ready are both high.
// ---------------------------------------------------------------------------
interface egcd_req_if;
    import egcd_pkg::*;
    logic   valid;
    logic   ready;
    t_field first_number;
    t_field second_number;

    modport source (output valid, output first_number, output second_number, input ready);
    modport sink   (input valid, input first_number, input second_number, output ready);
endinterface

interface egcd_rsp_if;
    import egcd_pkg::*;
    logic   valid;
    logic   ready;
    t_field gcd_value;
    t_field bezout_s;
    t_field bezout_t;
    t_field cofactor_t;
    t_field cofactor_s;
    logic   zero_operand;

    modport source (output valid, output gcd_value, output bezout_s, output bezout_t,
                    output cofactor_t, output cofactor_s, output zero_operand, input ready);
    modport sink   (input valid, input gcd_value, input bezout_s, input bezout_t,
                    input cofactor_t, input cofactor_s, input zero_operand, output ready);
endinterface

// File: hw/rtl/egcd_divmul.sv
// ---------------------------------------------------------------------------
// egcd_divmul: serial divider with quotient-times-coefficient accumulators
// Restoring division, one quotient bit per cycle, MSB first. Each quotient
// bit is folded into two Horner accumulators, giving q*s and q*t for free.
// ---------------------------------------------------------------------------
module egcd_divmul
    import egcd_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_res o_res
);

    logic [CNT_W-1:0] r_cnt, n_cnt;
    t_word            r_dvd, n_dvd;
    t_word            r_dvs, n_dvs;
    t_word            r_rem, n_rem;
    t_word            r_ms, n_ms;
    t_word            r_mt, n_mt;
    t_word            r_acc_s, n_acc_s;
    t_word            r_acc_t, n_acc_t;

    logic [WIDTH:0]   trial;
    logic [WIDTH:0]   diff;
    logic             q_bit;

    assign trial = {r_rem, r_dvd[WIDTH-1]};
    assign diff  = trial - {1'b0, r_dvs};
    assign q_bit = (trial >= {1'b0, r_dvs});

    always_comb begin
        n_cnt   = r_cnt;
        n_dvd   = r_dvd;
        n_dvs   = r_dvs;
        n_rem   = r_rem;
        n_ms    = r_ms;
        n_mt    = r_mt;
        n_acc_s = r_acc_s;
        n_acc_t = r_acc_t;
        if (i_req.start) begin
            n_cnt   = CNT_W'(WIDTH);
            n_dvd   = i_req.dividend;
            n_dvs   = i_req.divisor;
            n_rem   = '0;
            n_ms    = i_req.mul_s;
            n_mt    = i_req.mul_t;
            n_acc_s = '0;
            n_acc_t = '0;
        end else if (r_cnt != '0) begin
            n_cnt   = r_cnt - CNT_W'(1);
            n_dvd   = {r_dvd[WIDTH-2:0], 1'b0};
            n_rem   = q_bit ? diff[WIDTH-1:0] : trial[WIDTH-1:0];
            n_acc_s = {r_acc_s[WIDTH-2:0], 1'b0} + (q_bit ? r_ms : '0);
            n_acc_t = {r_acc_t[WIDTH-2:0], 1'b0} + (q_bit ? r_mt : '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dvd   <= n_dvd;
        r_dvs   <= n_dvs;
        r_rem   <= n_rem;
        r_ms    <= n_ms;
        r_mt    <= n_mt;
        r_acc_s <= n_acc_s;
        r_acc_t <= n_acc_t;
    end

    assign o_res.busy      = (r_cnt != '0);
    assign o_res.remainder = r_rem;
    assign o_res.prod_s    = r_acc_s;
    assign o_res.prod_t    = r_acc_t;

endmodule

// File: hw/rtl/extended_gcd_unit.sv
// ---------------------------------------------------------------------------
// extended_gcd_unit: extended Euclidean algorithm, truncating division
// Iterative sequencer around one shared serial divide/multiply unit.
// ---------------------------------------------------------------------------
// Usage:
//   i_req carries a request (first_number a, second_number b). o_rsp returns
//   one response per request: gcd_value, Bezout pair bezout_s/bezout_t with
//   s*a + t*b = gcd, the final chain coefficients cofactor_t/cofactor_s,
//   and zero_operand, set (all other fields zero) when a or b is zero.
//   i_req.ready is high only while the sequencer is idle; one request is in
//   work at a time.
// Timing:
//   Each Euclid step loads the divider, runs the restoring division in the
//   serial divider, MSB first, and then updates the remainder/coefficient
//   chain. A request runs one such step per quotient of the chain; a zero
//   operand skips the divider and goes straight to the finish state.
// Reset and stall:
//   Synchronous active-low reset returns to idle and drops o_rsp.valid.
//   The response sits in an output register; a new request is accepted
//   while it waits. If the receiver still stalls when the next result is
//   done, the sequencer holds it until the output register frees up.
// ---------------------------------------------------------------------------
module extended_gcd_unit
    import egcd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    egcd_req_if.sink    i_req,
    egcd_rsp_if.source  o_rsp
);

    t_state   r_state, n_state;

    // remainder and coefficient chain
    t_word    r_old_r, n_old_r;
    t_word    r_r,     n_r;
    t_word    r_old_s, n_old_s;
    t_word    r_s,     n_s;
    t_word    r_old_t, n_old_t;
    t_word    r_t,     n_t;
    logic     r_zero,  n_zero;

    // output register
    logic     r_out_valid, n_out_valid;
    t_field   r_gcd, r_bs, r_bt, r_ct, r_cs;
    logic     r_out_zero;

    t_div_req div_req;
    t_div_res div_res;

    // sequencer controls
    logic     accept;
    logic     div_start;
    logic     step_done;
    logic     out_load;

    // step results
    logic     q_neg;
    t_word    next_rem;
    t_word    qs, qt;
    t_word    in_a, in_b;
    logic     in_zero;

    egcd_divmul u_divmul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_res   (div_res)
    );

    assign in_a    = from_field(i_req.first_number);
    assign in_b    = from_field(i_req.second_number);
    assign in_zero = (in_a == '0) || (in_b == '0);

    // sign fix-up of the magnitude results: remainder follows the dividend,
    // quotient is negative when the operand signs differ
    assign q_neg    = r_old_r[WIDTH-1] ^ r_r[WIDTH-1];
    assign next_rem = r_old_r[WIDTH-1] ? (~div_res.remainder + WIDTH'(1)) : div_res.remainder;
    assign qs       = q_neg ? (~div_res.prod_s + WIDTH'(1)) : div_res.prod_s;
    assign qt       = q_neg ? (~div_res.prod_t + WIDTH'(1)) : div_res.prod_t;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_req.valid) begin
                    n_state = in_zero ? ST_FINISH : ST_DIV_START;
                end
            end
            ST_DIV_START: n_state = ST_DIV_RUN;
            ST_DIV_RUN: begin
                if (!div_res.busy) begin
                    n_state = (next_rem == '0) ? ST_FINISH : ST_DIV_START;
                end
            end
            ST_FINISH: begin
                if (!r_out_valid || o_rsp.ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        accept    = 1'b0;
        div_start = 1'b0;
        step_done = 1'b0;
        out_load  = 1'b0;
        case (r_state)
            ST_IDLE:      accept    = i_req.valid;
            ST_DIV_START: div_start = 1'b1;
            ST_DIV_RUN:   step_done = !div_res.busy;
            ST_FINISH:    out_load  = !r_out_valid || o_rsp.ready;
            default: ;
        endcase
    end

    assign i_req.ready = (r_state == ST_IDLE);

    always_comb begin
        div_req.start    = div_start;
        div_req.dividend = magnitude(r_old_r);
        div_req.divisor  = magnitude(r_r);
        div_req.mul_s    = r_s;
        div_req.mul_t    = r_t;
    end

    // chain update
    always_comb begin
        n_old_r = r_old_r;
        n_r     = r_r;
        n_old_s = r_old_s;
        n_s     = r_s;
        n_old_t = r_old_t;
        n_t     = r_t;
        n_zero  = r_zero;
        if (accept) begin
            n_zero = in_zero;
            if (in_zero) begin
                n_old_r = '0;
                n_r     = '0;
                n_old_s = '0;
                n_s     = '0;
                n_old_t = '0;
                n_t     = '0;
            end else begin
                n_old_r = in_a;
                n_r     = in_b;
                n_old_s = WIDTH'(1);
                n_s     = '0;
                n_old_t = '0;
                n_t     = WIDTH'(1);
            end
        end else if (step_done) begin
            n_old_r = r_r;
            n_r     = next_rem;
            n_old_s = r_s;
            n_s     = r_old_s - qs;
            n_old_t = r_t;
            n_t     = r_old_t - qt;
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (out_load) begin
            n_out_valid = 1'b1;
        end else if (o_rsp.ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_old_r <= n_old_r;
        r_r     <= n_r;
        r_old_s <= n_old_s;
        r_s     <= n_s;
        r_old_t <= n_old_t;
        r_t     <= n_t;
        r_zero  <= n_zero;
        if (out_load) begin
            r_gcd      <= to_field(r_old_r);
            r_bs       <= to_field(r_old_s);
            r_bt       <= to_field(r_old_t);
            r_ct       <= to_field(r_t);
            r_cs       <= to_field(r_s);
            r_out_zero <= r_zero;
        end
    end

    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.gcd_value    = r_gcd;
    assign o_rsp.bezout_s     = r_bs;
    assign o_rsp.bezout_t     = r_bt;
    assign o_rsp.cofactor_t   = r_ct;
    assign o_rsp.cofactor_s   = r_cs;
    assign o_rsp.zero_operand = r_out_zero;

endmodule

// File: tb/tb.sv
// ---------------------------------------------------------------------------
// tb: self-checking bench for extended_gcd_unit
// Drives operand pairs over the request channel and predicts every response
// with an in-bench extended Euclid chain. Each response is compared field by
// field, in order. The sender idles in bursts and the receiver stalls on its
// own pattern.
// ---------------------------------------------------------------------------
module tb;
    import egcd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Expected response, with the operands kept for error messages
    typedef struct {
        t_field first_number;
        t_field second_number;
        t_field gcd_value;
        t_field bezout_s;
        t_field bezout_t;
        t_field cofactor_t;
        t_field cofactor_s;
        logic   zero_operand;
    } t_gcd_result;

    // Receiver stall patterns
    typedef enum int {
        RDY_ALWAYS,
        RDY_COIN,
        RDY_SPARSE,
        RDY_HOLD_OFF
    } t_ready_mode;

    logic i_clk;
    logic i_rst_n;

    egcd_req_if req_ch ();
    egcd_rsp_if rsp_ch ();

    extended_gcd_unit uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    t_gcd_result expected_responses[$];

    int failures       = 0;
    int requests_sent  = 0;
    int responses_seen = 0;
    int zero_cases     = 0;
    int longest_chain  = 0;
    int burst_left     = 0;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Watchdog: far beyond a run where every request takes the longest chain
    // and every response waits out the longest receiver stall.
    initial begin
        #50_000_000;
        $display("TIMEOUT: %0d requests sent, %0d responses seen, %0d still expected",
                 requests_sent, responses_seen, expected_responses.size());
        $display("extended_gcd_unit verification failed");
        $finish;
    end

    // -----------------------------------------------------------------------
    // Prediction: remainder chain with truncating division. Quotients come
    // from exact magnitudes, so even the most negative value ends the chain;
    // all products and differences wrap at WIDTH bits.
    // -----------------------------------------------------------------------
    function automatic t_gcd_result euclid_expected(input t_field a_f, input t_field b_f,
                                                    output int chain_steps);
        logic signed [63:0] wide;
        t_word       a, b;
        t_word       old_r, r, old_s, s, old_t, t;
        t_word       num_mag, den_mag, qm, q, nxt;
        t_gcd_result res;

        res.first_number  = a_f;
        res.second_number = b_f;
        chain_steps       = 0;

        // sign extend the 32-bit fields, keep the datapath width
        wide = 64'($signed(a_f));
        a    = wide[WIDTH-1:0];
        wide = 64'($signed(b_f));
        b    = wide[WIDTH-1:0];

        if (a == '0 || b == '0) begin
            res.gcd_value    = '0;
            res.bezout_s     = '0;
            res.bezout_t     = '0;
            res.cofactor_t   = '0;
            res.cofactor_s   = '0;
            res.zero_operand = 1'b1;
            return res;
        end

        old_r = a;  r = b;
        old_s = t_word'(1);  s = '0;
        old_t = '0; t = t_word'(1);

        while (r != '0) begin
            num_mag = old_r[WIDTH-1] ? t_word'('0 - old_r) : old_r;
            den_mag = r[WIDTH-1]     ? t_word'('0 - r)     : r;
            qm      = num_mag / den_mag;
            q       = (old_r[WIDTH-1] != r[WIDTH-1]) ? t_word'('0 - qm) : qm;

            nxt = old_r - q * r; old_r = r; r = nxt;
            nxt = old_s - q * s; old_s = s; s = nxt;
            nxt = old_t - q * t; old_t = t; t = nxt;
            chain_steps++;
        end

        // back to field width, sign extended from the datapath
        wide = 64'($signed(old_r)); res.gcd_value  = wide[FIELD_W-1:0];
        wide = 64'($signed(old_s)); res.bezout_s   = wide[FIELD_W-1:0];
        wide = 64'($signed(old_t)); res.bezout_t   = wide[FIELD_W-1:0];
        wide = 64'($signed(t));     res.cofactor_t = wide[FIELD_W-1:0];
        wide = 64'($signed(s));     res.cofactor_s = wide[FIELD_W-1:0];
        res.zero_operand = 1'b0;
        return res;
    endfunction

    // -----------------------------------------------------------------------
    // Request side. valid stays up across a burst; at the end of a burst it
    // drops for a random gap. The expectation is queued on acceptance.
    // -----------------------------------------------------------------------
    task automatic send_request(input t_field a, input t_field b);
        t_gcd_result want;
        int          steps;

        if (burst_left == 0) begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
            // now and then a long burst, so stretches with no sender idling
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(1, 6);
        end

        req_ch.valid         <= 1'b1;
        req_ch.first_number  <= a;
        req_ch.second_number <= b;

        do @(posedge i_clk); while (!(req_ch.valid && req_ch.ready));

        want = euclid_expected(a, b, steps);
        expected_responses.push_back(want);
        requests_sent++;
        burst_left--;
        if (want.zero_operand) zero_cases++;
        if (steps > longest_chain) longest_chain = steps;
    endtask

    // Drop valid and hold off until every outstanding response is back.
    task automatic pause_until_drained();
        req_ch.valid <= 1'b0;
        burst_left = 0;
        do @(posedge i_clk); while (expected_responses.size() != 0);
    endtask

    // -----------------------------------------------------------------------
    // Response side: ready follows a mode that is redrawn at random
    // intervals, so stalls land on every phase of the sequencer.
    // -----------------------------------------------------------------------
    t_ready_mode ready_mode = RDY_ALWAYS;
    int          mode_left  = 0;

    always @(posedge i_clk) begin
        if (mode_left == 0) begin
            ready_mode = t_ready_mode'($urandom_range(0, 3));
            mode_left  = $urandom_range(8, 64);
        end
        mode_left--;
        case (ready_mode)
            RDY_ALWAYS:   rsp_ch.ready <= 1'b1;
            RDY_COIN:     rsp_ch.ready <= 1'($urandom_range(0, 1));
            RDY_SPARSE:   rsp_ch.ready <= ($urandom_range(0, 5) == 0);
            default:      rsp_ch.ready <= 1'b0;
        endcase
    end

    function automatic void check_field(input string name, input t_gcd_result want,
                                        input t_field exp_v, input t_field act_v);
        if (exp_v !== act_v) begin
            $error("%s mismatch for a=%0d b=%0d: expected %0d, got %0d", name,
                   $signed(want.first_number), $signed(want.second_number),
                   $signed(exp_v), $signed(act_v));
            failures++;
        end
    endfunction

    // Every accepted response is matched against the oldest expectation.
    always @(posedge i_clk) begin : check_responses
        t_gcd_result want;
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            responses_seen++;
            if (expected_responses.size() == 0) begin
                $error("response with no request outstanding: gcd_value=%0d",
                       $signed(rsp_ch.gcd_value));
                failures++;
            end else begin
                want = expected_responses.pop_front();
                check_field("gcd_value",  want, want.gcd_value,  rsp_ch.gcd_value);
                check_field("bezout_s",   want, want.bezout_s,   rsp_ch.bezout_s);
                check_field("bezout_t",   want, want.bezout_t,   rsp_ch.bezout_t);
                check_field("cofactor_t", want, want.cofactor_t, rsp_ch.cofactor_t);
                check_field("cofactor_s", want, want.cofactor_s, rsp_ch.cofactor_s);
                if (want.zero_operand !== rsp_ch.zero_operand) begin
                    $error("zero_operand mismatch for a=%0d b=%0d: expected %0b, got %0b",
                           $signed(want.first_number), $signed(want.second_number),
                           want.zero_operand, rsp_ch.zero_operand);
                    failures++;
                end
            end
        end
    end

    // -----------------------------------------------------------------------
    // Directed cases
    // -----------------------------------------------------------------------

    // Either operand zero: all fields zero and the flag raised.
    task automatic test_zero_operands();
        send_request(32'sd0, 32'sd0);
        send_request(32'sd0, 32'sd5);
        send_request(32'sd7, 32'sd0);
        send_request(32'sd0, 32'h8000_0001);
        send_request(32'h8000_0000, 32'sd0);
    endtask

    // Field extremes, including the most negative value, whose quotient
    // against -1 wraps.
    task automatic test_extreme_operands();
        send_request(32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_request(32'h7FFF_FFFF, 32'h8000_0001);
        send_request(32'h8000_0001, 32'h7FFF_FFFF);
        send_request(32'h8000_0000, 32'sd1);
        send_request(32'h8000_0000, 32'hFFFF_FFFF);
        send_request(32'h8000_0000, 32'h8000_0000);
        send_request(32'sd1, 32'h8000_0000);
        send_request(32'h7FFF_FFFF, 32'h8000_0000);
        send_request(32'sd1, 32'sd1);
        send_request(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(32'sd1, 32'hFFFF_FFFF);
    endtask

    // Chain shapes: one step, exact multiples, mixed signs, and the longest
    // chain (consecutive Fibonacci numbers).
    task automatic test_chain_shapes();
        send_request(32'sd12, 32'sd4);
        send_request(32'sd4, 32'sd12);
        send_request(-32'sd7, 32'sd3);
        send_request(32'sd7, -32'sd3);
        send_request(32'sd240, 32'sd46);
        send_request(32'sd1836311903, 32'sd1134903170);
        send_request(-32'sd1134903170, 32'sd1836311903);
    endtask

    // -----------------------------------------------------------------------
    // Random operands: full-range words for bit coverage, small values,
    // shared factors, Fibonacci pairs for long chains, zeros and extremes.
    // -----------------------------------------------------------------------
    function automatic t_field small_operand();
        t_field m;
        m = $urandom_range(1, 1000);
        return $urandom_range(0, 1) ? t_field'('0 - m) : m;
    endfunction

    task automatic test_random_operands(input int count);
        t_field      a, b, swap;
        longint      fa, fb, fn;
        int          kind, g;
        t_field      edge_values[5];

        edge_values = '{32'h7FFF_FFFF, 32'h8000_0001, 32'h8000_0000, 32'sd1, 32'hFFFF_FFFF};

        for (int n = 0; n < count; n++) begin
            kind = $urandom_range(0, 99);
            if (kind < 45) begin
                a = $urandom;
                b = $urandom;
            end else if (kind < 65) begin
                a = small_operand();
                b = small_operand();
            end else if (kind < 78) begin
                // common factor up to 16 bits, product stays inside the field
                g = $urandom_range(1, 65535);
                a = t_field'(g * $urandom_range(1, 32767));
                b = t_field'(g * $urandom_range(1, 32767));
                if ($urandom_range(0, 1)) a = '0 - a;
                if ($urandom_range(0, 1)) b = '0 - b;
            end else if (kind < 88) begin
                fa = 1;
                fb = 1;
                repeat ($urandom_range(1, 44)) begin
                    fn = fa + fb;
                    fb = fa;
                    fa = fn;
                end
                a = t_field'(fa);
                b = t_field'(fb);
                if ($urandom_range(0, 1)) a = '0 - a;
                if ($urandom_range(0, 1)) b = '0 - b;
            end else if (kind < 94) begin
                a = $urandom_range(0, 1) ? t_field'($urandom) : '0;
                b = (a == '0) ? t_field'($urandom) : '0;
            end else begin
                a = edge_values[$urandom_range(0, 4)];
                b = edge_values[$urandom_range(0, 4)];
            end

            if ($urandom_range(0, 1)) begin
                swap = a;
                a    = b;
                b    = swap;
            end

            send_request(a, b);

            if (n == count / 2) pause_until_drained();
        end
    endtask

    // -----------------------------------------------------------------------
    // Sequence
    // -----------------------------------------------------------------------
    initial begin
        i_rst_n              = 1'b0;
        req_ch.valid         = 1'b0;
        req_ch.first_number  = '0;
        req_ch.second_number = '0;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_zero_operands();
        test_extreme_operands();
        test_chain_shapes();
        // sender holds off here until the unit has answered everything
        pause_until_drained();

        test_random_operands(370);
        pause_until_drained();

        // nothing should follow the last expected response
        repeat (100) @(posedge i_clk);

        $display("Covered %0d requests (%0d with a zero operand), %0d responses checked,",
                 requests_sent, zero_cases, responses_seen);
        $display("longest remainder chain %0d steps, %0d mismatches",
                 longest_chain, failures);

        if (failures == 0 && expected_responses.size() == 0) begin
            $display("extended_gcd_unit verification clean");
        end else begin
            $display("extended_gcd_unit verification failed");
        end
        $finish;
    end

endmodule
